>>> rtl/core/lkvc_pkg.sv
// Shared constants and types for the LRU key-value cache.
// No dependencies; imported by the control unit and the top level.
package lkvc_pkg;

    localparam int KEY_W           = 32;
    localparam int VAL_W           = 32;
    localparam int CAP_W           = 5;
    localparam int ENTRIES_DEFAULT = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic
    {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } op_t;

endpackage

>>> rtl/core/lru_key_value_cache.sv
// Top level of the LRU key-value cache: capacity register, sequencer and two RAMs.
// Depends on lkvc_pkg, lkvc_ram and lkvc_ctrl.
//
// Usage:
//   Command channel: drive operation (0 get, 1 put), key and value and raise
//   start; the item is taken at a clock edge where start is high and busy is
//   low. busy stays high until the item is fully processed.
//   Result channel: done pulses high for one cycle with hit and data valid.
//   hit tells whether the key was present; data is the stored value on a get
//   hit and zero otherwise. The receiver cannot stall; results must be taken
//   in the cycle done is high.
//   Configuration: cfg_data is written into the capacity register at an edge
//   where cfg_valid is high; cfg_ready is always high. Write it only while
//   busy is low. A capacity of 0 acts as 1, above ENTRIES acts as ENTRIES.
//   Timing: each item scans every entry of the tag RAM one per cycle, then,
//   except on a get miss, a second pass over the same RAM rewrites the
//   recency ranks. A new item can be taken in the cycle done is high. The
//   single read port of the tag RAM sets this pace.
//   Reset: all entries become invalid, occupancy is zero and capacity is 16.
module lru_key_value_cache
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     operation,
    input  logic signed [KEY_W-1:0]  key,
    input  logic signed [VAL_W-1:0]  value,
    output logic                     done,
    output logic                     hit,
    output logic signed [VAL_W-1:0]  data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CAP_W-1:0]         cfg_data
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam int TAG_W  = KEY_W + RANK_W;

    logic [CAP_W-1:0]  capacity_reg;
    logic [CMP_W-1:0]  cap_wide;
    logic [CMP_W-1:0]  cap_clamp;
    logic [OCC_W-1:0]  cap_eff;

    logic              tag_we;
    logic [IDX_W-1:0]  tag_waddr;
    logic [TAG_W-1:0]  tag_wdata;
    logic              tag_re;
    logic [IDX_W-1:0]  tag_raddr;
    logic [TAG_W-1:0]  tag_rdata;
    logic              val_we;
    logic [IDX_W-1:0]  val_waddr;
    logic [VAL_W-1:0]  val_wdata;
    logic              val_re;
    logic [IDX_W-1:0]  val_raddr;
    logic [VAL_W-1:0]  val_rdata;
    logic [VAL_W-1:0]  data_raw;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_valid)
        begin
            capacity_reg <= cfg_data;
        end
    end

    // Clamp capacity into 1..ENTRIES.
    always_comb
    begin
        cap_wide = CMP_W'(capacity_reg);
        priority if (cap_wide == '0)
        begin
            cap_clamp = CMP_W'(1);
        end
        else if (cap_wide > CMP_W'(ENTRIES))
        begin
            cap_clamp = CMP_W'(ENTRIES);
        end
        else
        begin
            cap_clamp = cap_wide;
        end
        cap_eff = cap_clamp[OCC_W-1:0];
    end

    lkvc_ctrl #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W),
        .RANK_W  (RANK_W),
        .OCC_W   (OCC_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .key       (KEY_W'(key)),
        .value     (VAL_W'(value)),
        .cap_eff   (cap_eff),
        .done      (done),
        .hit       (hit),
        .data      (data_raw),
        .tag_we    (tag_we),
        .tag_waddr (tag_waddr),
        .tag_wdata (tag_wdata),
        .tag_re    (tag_re),
        .tag_raddr (tag_raddr),
        .tag_rdata (tag_rdata),
        .val_we    (val_we),
        .val_waddr (val_waddr),
        .val_wdata (val_wdata),
        .val_re    (val_re),
        .val_raddr (val_raddr),
        .val_rdata (val_rdata)
    );

    assign data = signed'(data_raw);

    lkvc_ram #(
        .WIDTH (TAG_W),
        .DEPTH (ENTRIES),
        .AW    (IDX_W)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .re    (tag_re),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    lkvc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (ENTRIES),
        .AW    (IDX_W)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .re    (val_re),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

endmodule

>>> rtl/core/lkvc_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
// No dependencies; used for the tag/rank store and the value store.
module lkvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/lkvc_ctrl.sv
// Sequencer for the LRU cache: scan pass over the tag store, decision, rank update pass.
// Depends on lkvc_pkg; drives the two lkvc_ram instances in the top level.
module lkvc_ctrl
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT,
    parameter int IDX_W   = 4,
    parameter int RANK_W  = 4,
    parameter int OCC_W   = 5
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     operation,
    input  logic [KEY_W-1:0]         key,
    input  logic [VAL_W-1:0]         value,
    input  logic [OCC_W-1:0]         cap_eff,
    output logic                     done,
    output logic                     hit,
    output logic [VAL_W-1:0]         data,
    output logic                     tag_we,
    output logic [IDX_W-1:0]         tag_waddr,
    output logic [KEY_W+RANK_W-1:0]  tag_wdata,
    output logic                     tag_re,
    output logic [IDX_W-1:0]         tag_raddr,
    input  logic [KEY_W+RANK_W-1:0]  tag_rdata,
    output logic                     val_we,
    output logic [IDX_W-1:0]         val_waddr,
    output logic [VAL_W-1:0]         val_wdata,
    output logic                     val_re,
    output logic [IDX_W-1:0]         val_raddr,
    input  logic [VAL_W-1:0]         val_rdata
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE
    } state_t;

    state_t               state_reg;
    op_t                  op_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [VAL_W-1:0]     val_reg;
    logic [ENTRIES-1:0]   valid_reg;
    logic [OCC_W-1:0]     occ_reg;
    logic [IDX_W-1:0]     addr_reg;
    logic                 issue_reg;
    logic                 rd_vld_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     match_idx_reg;
    logic [RANK_W-1:0]    match_rank_reg;
    logic                 free_reg;
    logic [IDX_W-1:0]     free_idx_reg;
    logic                 lru_have_reg;
    logic [IDX_W-1:0]     lru_idx_reg;
    logic [RANK_W-1:0]    lru_rank_reg;
    logic [IDX_W-1:0]     target_reg;
    logic [RANK_W-1:0]    old_rank_reg;
    logic                 age_all_reg;
    logic                 done_reg;
    logic                 hit_reg;
    logic [VAL_W-1:0]     data_reg;

    logic [KEY_W-1:0]     rd_key;
    logic [RANK_W-1:0]    rd_rank;
    logic                 rd_valid;
    logic                 rd_last;
    logic                 is_target;
    logic                 do_age;

    logic                 dec_upd;
    logic                 dec_fill;
    logic                 dec_val_we;
    logic [IDX_W-1:0]     dec_target;
    logic [RANK_W-1:0]    dec_old;
    logic                 dec_age_all;

    assign rd_key   = tag_rdata[KEY_W+RANK_W-1:RANK_W];
    assign rd_rank  = tag_rdata[RANK_W-1:0];
    assign rd_valid = valid_reg[rd_idx_reg];
    assign rd_last  = (rd_idx_reg == LAST_IDX);

    assign is_target = (rd_idx_reg == target_reg);
    assign do_age    = rd_valid && (age_all_reg || (rd_rank < old_rank_reg));

    // Pick the entry to touch once the scan has settled.
    always_comb
    begin
        dec_upd     = 1'b0;
        dec_fill    = 1'b0;
        dec_val_we  = 1'b0;
        dec_target  = match_idx_reg;
        dec_old     = match_rank_reg;
        dec_age_all = 1'b0;
        if (found_reg)
        begin
            dec_upd    = 1'b1;
            dec_val_we = (op_reg == OP_PUT);
        end
        else if (op_reg == OP_PUT)
        begin
            if ((occ_reg < cap_eff) && free_reg)
            begin
                dec_upd     = 1'b1;
                dec_fill    = 1'b1;
                dec_val_we  = 1'b1;
                dec_target  = free_idx_reg;
                dec_age_all = 1'b1;
            end
            else if (lru_have_reg)
            begin
                dec_upd    = 1'b1;
                dec_val_we = 1'b1;
                dec_target = lru_idx_reg;
                dec_old    = lru_rank_reg;
            end
        end
    end

    // Memory ports
    always_comb
    begin
        tag_re    = issue_reg && ((state_reg == ST_SCAN) || (state_reg == ST_UPDATE));
        tag_raddr = addr_reg;
        tag_waddr = rd_idx_reg;
        tag_we    = (state_reg == ST_UPDATE) && rd_vld_reg && (is_target || do_age);
        if (is_target)
        begin
            tag_wdata = {key_reg, {RANK_W{1'b0}}};
        end
        else
        begin
            tag_wdata = {rd_key, rd_rank + 1'b1};
        end
        val_we    = (state_reg == ST_DECIDE) && dec_val_we;
        val_waddr = dec_target;
        val_wdata = val_reg;
        val_re    = (state_reg == ST_DECIDE) && found_reg && (op_reg == OP_GET);
        val_raddr = match_idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            valid_reg  <= '0;
            occ_reg    <= '0;
            issue_reg  <= 1'b0;
            rd_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        op_reg       <= op_t'(operation);
                        key_reg      <= key;
                        val_reg      <= value;
                        addr_reg     <= '0;
                        issue_reg    <= 1'b1;
                        rd_vld_reg   <= 1'b0;
                        found_reg    <= 1'b0;
                        free_reg     <= 1'b0;
                        lru_have_reg <= 1'b0;
                        state_reg    <= ST_SCAN;
                    end
                end

                ST_SCAN, ST_UPDATE:
                begin
                    // Advance the read address; the RAM returns its data on the next cycle.
                    rd_vld_reg <= issue_reg;
                    rd_idx_reg <= addr_reg;
                    if (issue_reg)
                    begin
                        if (addr_reg == LAST_IDX)
                        begin
                            issue_reg <= 1'b0;
                        end
                        else
                        begin
                            addr_reg <= addr_reg + 1'b1;
                        end
                    end
                    if (rd_vld_reg && (state_reg == ST_SCAN))
                    begin
                        if (rd_valid && (rd_key == key_reg) && !found_reg)
                        begin
                            found_reg      <= 1'b1;
                            match_idx_reg  <= rd_idx_reg;
                            match_rank_reg <= rd_rank;
                        end
                        if (!rd_valid && !free_reg)
                        begin
                            free_reg     <= 1'b1;
                            free_idx_reg <= rd_idx_reg;
                        end
                        if (rd_valid && (!lru_have_reg || (rd_rank > lru_rank_reg)))
                        begin
                            lru_have_reg <= 1'b1;
                            lru_idx_reg  <= rd_idx_reg;
                            lru_rank_reg <= rd_rank;
                        end
                        if (rd_last)
                        begin
                            state_reg <= ST_DECIDE;
                        end
                    end
                    if (rd_vld_reg && (state_reg == ST_UPDATE) && rd_last)
                    begin
                        state_reg <= ST_IDLE;
                        done_reg  <= 1'b1;
                        hit_reg   <= found_reg;
                        data_reg  <= (found_reg && (op_reg == OP_GET)) ? val_rdata : '0;
                    end
                end

                ST_DECIDE:
                begin
                    target_reg   <= dec_target;
                    old_rank_reg <= dec_old;
                    age_all_reg  <= dec_age_all;
                    rd_vld_reg   <= 1'b0;
                    if (dec_fill)
                    begin
                        valid_reg[dec_target] <= 1'b1;
                        occ_reg               <= occ_reg + 1'b1;
                    end
                    if (dec_upd)
                    begin
                        addr_reg  <= '0;
                        issue_reg <= 1'b1;
                        state_reg <= ST_UPDATE;
                    end
                    else
                    begin
                        // Get miss: nothing changes, report at once.
                        state_reg <= ST_IDLE;
                        done_reg  <= 1'b1;
                        hit_reg   <= 1'b0;
                        data_reg  <= '0;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign hit  = hit_reg;
    assign data = data_reg;

endmodule
